>>> rtl/hvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared widths, register codes, angle constants and elaboration-time tables
// (arctangents, degree-to-radian scale, rotation gain) for the distance block.
// ----------------------------------------------------------------------------
package hvd_pkg;

  localparam int DefCordicSteps = 24;
  localparam int DefFracBits    = 30;

  localparam int UnitW    = 16;
  localparam int LatW     = 31;
  localparam int LonW     = 32;
  localparam int DistW    = 31;
  localparam int ThrW     = 16;
  localparam int RadW     = 23;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 23;

  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_RADIUS    = 1'b1;

  localparam logic [ThrW-1:0] ThrReset = 16'd100;
  localparam logic [RadW-1:0] RadReset = 23'd6371000;

  // angle units of half a 1e-7 degree
  localparam int AngW = 35;
  localparam int MagW = 31;
  localparam logic signed [AngW-1:0] TURN_UNITS    = 35'sd7200000000;
  localparam logic signed [AngW-1:0] HALF_UNITS    = 35'sd3600000000;
  localparam logic signed [AngW-1:0] QUARTER_UNITS = 35'sd1800000000;

  localparam logic [63:0] GAIN_Q60 = 64'd700114967507363226;

  localparam int MulLat = 3;

  localparam logic [1:0] SER_FIVE = 2'd0;
  localparam logic [1:0] SER_239  = 2'd1;
  localparam logic [1:0] SER_POW2 = 2'd2;

  // restoring long division, one quotient bit per pass
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent power series of 1/d in Q60, starting from p0 = 2^60 / d
  function automatic logic [63:0] atan_series(input logic [63:0] p0,
                                              input logic [1:0] kind,
                                              input int sh);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] odd;
    logic        sub;
    p   = p0;
    sum = 64'd0;
    odd = 64'd1;
    sub = 1'b0;
    while (p != 64'd0) begin
      t = udiv64(p, odd);
      if (sub) sum = sum - t;
      else sum = sum + t;
      unique case (kind)
        SER_FIVE: p = p / 64'd25;
        SER_239:  p = p / 64'd57121;
        default:  p = p >> sh;
      endcase
      odd = odd + 64'd2;
      sub = ~sub;
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] s5;
    logic [63:0] s239;
    s5   = atan_series((64'd1 << 60) / 64'd5, SER_FIVE, 0);
    s239 = atan_series((64'd1 << 60) / 64'd239, SER_239, 0);
    if (i == 0) return (s5 << 2) - s239;
    return atan_series(64'd1 << (60 - i), SER_POW2, 2 * i);
  endfunction

  function automatic logic [63:0] atan_qf(input int i, input int f);
    return atan_q60(i) >> (60 - f);
  endfunction

  function automatic logic [63:0] rad_scale_q92();
    logic [63:0] pi60;
    logic [63:0] q;
    logic [63:0] r;
    pi60 = atan_q60(0) << 2;
    q    = pi60 / 64'd1800000000;
    r    = pi60 % 64'd1800000000;
    return (q << 32) + ((r << 32) / 64'd1800000000);
  endfunction

  function automatic logic [63:0] gain_qf(input int f);
    return GAIN_Q60 >> (60 - f);
  endfunction

endpackage

>>> rtl/haversine_distance_proximity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_proximity
// Great-circle distance between two positions and an in-range flag.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with both positions and unit ids on the in_ ports; the item
//   is taken on any edge where busy is low. busy is high only just after
//   reset, so a new item can be given every cycle.
//   Each result appears for one cycle with out_valid high, in the same order
//   as the items. The pipeline holds the rotation chain (one cell per
//   iteration), the square-root chain (FRAC_BITS+1 cells), the vectoring
//   chain, three 3-stage multipliers in series and eight single registers
//   (angle in, wrap, fold, radian scale, angle out, sine/cosine, a,
//   result); one item per cycle.
//   The receiver has no way to stall: results must be taken when shown.
//   Threshold and radius are written through cfg_we/cfg_index/cfg_wdata and
//   must only change while no item is in flight.
//   Reset clears all items in flight and restores threshold 100 m and
//   radius 6371000 m.
// ----------------------------------------------------------------------------
module haversine_distance_proximity #(
  parameter int CORDIC_STEPS = hvd_pkg::DefCordicSteps,
  parameter int FRAC_BITS    = hvd_pkg::DefFracBits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [hvd_pkg::UnitW-1:0]     in_own_unit,
  input  logic signed [hvd_pkg::LatW-1:0] in_own_lat,
  input  logic signed [hvd_pkg::LonW-1:0] in_own_lon,
  input  logic [hvd_pkg::UnitW-1:0]     in_peer_unit,
  input  logic signed [hvd_pkg::LatW-1:0] in_peer_lat,
  input  logic signed [hvd_pkg::LonW-1:0] in_peer_lon,
  input  logic                          cfg_we,
  input  logic [hvd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hvd_pkg::CfgDataW-1:0]  cfg_wdata,
  output logic                          out_valid,
  output logic [hvd_pkg::DistW-1:0]     out_distance_cm,
  output logic                          out_in_range,
  output logic                          out_same_unit
);
  import hvd_pkg::*;

  localparam int W       = FRAC_BITS + 3;
  localparam int QW      = FRAC_BITS + 2;
  localparam int RW      = FRAC_BITS + 5;
  localparam int NLane   = 4;
  localparam int LATENCY = 2 * CORDIC_STEPS + FRAC_BITS + 18;
  localparam int R100W   = 31;
  localparam int DW      = 34;
  localparam logic [63:0] RadScale = rad_scale_q92();
  localparam logic [63:0] GainFull = gain_qf(FRAC_BITS);
  localparam logic signed [W-1:0] Gain = GainFull[W-1:0];
  localparam logic signed [W:0] One = (W+1)'(1) <<< FRAC_BITS;

  // configuration
  logic [ThrW-1:0] thr_r;
  logic [RadW-1:0] rad_r;
  logic            busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= ThrReset;
      rad_r  <= RadReset;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: thr_r <= cfg_wdata[ThrW-1:0];
          REG_RADIUS:    rad_r <= cfg_wdata[RadW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  logic accept;
  assign accept = start & ~busy_r;

  // valid and same-id flags travel beside the datapath
  logic [LATENCY-2:0] vld_r;
  logic [LATENCY-2:0] same_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LATENCY-3:0], accept};
  end

  always_ff @(posedge clk) begin
    same_r <= {same_r[LATENCY-3:0], in_own_unit == in_peer_unit};
  end

  // lanes: half lat difference, half lon difference, own lat, peer lat
  logic signed [AngW-1:0] ang_nxt [NLane];
  logic signed [AngW-1:0] ang_r [NLane];

  always_comb begin
    ang_nxt[0] = AngW'(in_peer_lat) - AngW'(in_own_lat);
    ang_nxt[1] = AngW'(in_peer_lon) - AngW'(in_own_lon);
    ang_nxt[2] = AngW'(in_own_lat) <<< 1;
    ang_nxt[3] = AngW'(in_peer_lat) <<< 1;
  end

  always_ff @(posedge clk) begin
    ang_r <= ang_nxt;
  end

  logic signed [W-1:0] sin_w [NLane];
  logic signed [W-1:0] cos_w [NLane];

  for (genvar ln = 0; ln < NLane; ln++) begin : g_lane
    logic signed [AngW-1:0] wr_r, wr_nxt;
    logic signed [AngW-1:0] fold, absv;
    logic [MagW-1:0]        mag_r, mag_nxt;
    logic                   neg_r, neg_nxt, neg2_r;
    logic                   flip_r, flip_nxt, flip2_r, flip3_r;
    logic [62:0]            lo_r;
    logic [61:0]            hi_r;
    logic [93:0]            zsum, zsh;
    logic [W-1:0]           zmag;
    logic signed [W-1:0]    z_r;
    logic signed [W-1:0]    cx [CORDIC_STEPS+1];
    logic signed [W-1:0]    cy [CORDIC_STEPS+1];
    logic signed [W-1:0]    cz [CORDIC_STEPS+1];
    logic                   ct [CORDIC_STEPS+1];
    logic signed [W-1:0]    s_r, c_r;

    // wrap to half a turn either side
    always_comb begin
      wr_nxt = ang_r[ln];
      if (ang_r[ln] >= HALF_UNITS) wr_nxt = ang_r[ln] - TURN_UNITS;
      else if (ang_r[ln] < -HALF_UNITS) wr_nxt = ang_r[ln] + TURN_UNITS;
    end

    // fold into a quarter turn, remember to negate the cosine
    always_comb begin
      fold     = wr_r;
      flip_nxt = 1'b0;
      if (wr_r > QUARTER_UNITS) begin
        fold     = HALF_UNITS - wr_r;
        flip_nxt = 1'b1;
      end else if (wr_r < -QUARTER_UNITS) begin
        fold     = -HALF_UNITS - wr_r;
        flip_nxt = 1'b1;
      end
      neg_nxt = fold[AngW-1];
      absv    = neg_nxt ? -fold : fold;
      mag_nxt = absv[MagW-1:0];
    end

    always_comb begin
      zsum = {hi_r, 32'd0} + 94'(lo_r);
      zsh  = zsum >> (93 - FRAC_BITS);
      zmag = zsh[W-1:0];
    end

    always_ff @(posedge clk) begin
      wr_r    <= wr_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      flip_r  <= flip_nxt;
      lo_r    <= mag_r * RadScale[31:0];
      hi_r    <= mag_r * RadScale[62:32];
      neg2_r  <= neg_r;
      flip2_r <= flip_r;
      z_r     <= neg2_r ? -$signed(zmag) : $signed(zmag);
      flip3_r <= flip2_r;
    end

    assign cx[0] = Gain;
    assign cy[0] = '0;
    assign cz[0] = z_r;
    assign ct[0] = flip3_r;

    for (genvar st = 0; st < CORDIC_STEPS; st++) begin : g_rot
      hvd_rot_cell #(
        .FRAC_BITS(FRAC_BITS),
        .IDX      (st)
      ) u_cell (
        .clk  (clk),
        .x_i  (cx[st]),
        .y_i  (cy[st]),
        .z_i  (cz[st]),
        .tag_i(ct[st]),
        .x_o  (cx[st+1]),
        .y_o  (cy[st+1]),
        .z_o  (cz[st+1]),
        .tag_o(ct[st+1])
      );
    end

    always_ff @(posedge clk) begin
      s_r <= cy[CORDIC_STEPS];
      c_r <= ct[CORDIC_STEPS] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
    end

    assign sin_w[ln] = s_r;
    assign cos_w[ln] = c_r;
  end

  // a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2)
  logic signed [W-1:0] p_ss1, p_cc, p_ss2, p_mix;
  logic signed [W-1:0] p1d_r [MulLat];

  hvd_mul #(.AW(W), .BW(W), .OW(W), .SHIFT(FRAC_BITS)) u_mul_ss1 (
    .clk(clk), .a_i(sin_w[0]), .b_i(sin_w[0]), .p_o(p_ss1)
  );
  hvd_mul #(.AW(W), .BW(W), .OW(W), .SHIFT(FRAC_BITS)) u_mul_cc (
    .clk(clk), .a_i(cos_w[2]), .b_i(cos_w[3]), .p_o(p_cc)
  );
  hvd_mul #(.AW(W), .BW(W), .OW(W), .SHIFT(FRAC_BITS)) u_mul_ss2 (
    .clk(clk), .a_i(sin_w[1]), .b_i(sin_w[1]), .p_o(p_ss2)
  );
  hvd_mul #(.AW(W), .BW(W), .OW(W), .SHIFT(FRAC_BITS)) u_mul_mix (
    .clk(clk), .a_i(p_cc), .b_i(p_ss2), .p_o(p_mix)
  );

  always_ff @(posedge clk) begin
    p1d_r[0] <= p_ss1;
    for (int k = 1; k < MulLat; k++) p1d_r[k] <= p1d_r[k-1];
  end

  logic signed [W:0]  asum, aclamp, bval;
  logic [FRAC_BITS:0] a_r, b_r;

  always_comb begin
    asum = (W+1)'(p1d_r[MulLat-1]) + (W+1)'(p_mix);
    if (asum < 0) aclamp = '0;
    else if (asum > One) aclamp = One;
    else aclamp = asum;
    bval = One - aclamp;
  end

  always_ff @(posedge clk) begin
    a_r <= aclamp[FRAC_BITS:0];
    b_r <= bval[FRAC_BITS:0];
  end

  // square roots of a and 1-a, one result bit per cell
  logic [FRAC_BITS:0] sq_v [2][FRAC_BITS+2];
  logic [RW-1:0]      sq_r [2][FRAC_BITS+2];
  logic [QW-1:0]      sq_q [2][FRAC_BITS+2];

  assign sq_v[0][0] = a_r;
  assign sq_v[1][0] = b_r;

  for (genvar ch = 0; ch < 2; ch++) begin : g_sqrt
    assign sq_r[ch][0] = '0;
    assign sq_q[ch][0] = '0;
    for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_dig
      hvd_sqrt_cell #(
        .FRAC_BITS(FRAC_BITS),
        .STEP     (FRAC_BITS - j)
      ) u_cell (
        .clk(clk),
        .a_i(sq_v[ch][j]),
        .r_i(sq_r[ch][j]),
        .q_i(sq_q[ch][j]),
        .a_o(sq_v[ch][j+1]),
        .r_o(sq_r[ch][j+1]),
        .q_o(sq_q[ch][j+1])
      );
    end
  end

  // central angle by vectoring (sqrt(1-a), sqrt(a))
  logic signed [W-1:0] vx [CORDIC_STEPS+1];
  logic signed [W-1:0] vy [CORDIC_STEPS+1];
  logic signed [W-1:0] vz [CORDIC_STEPS+1];

  assign vx[0] = W'(sq_q[1][FRAC_BITS+1]);
  assign vy[0] = W'(sq_q[0][FRAC_BITS+1]);
  assign vz[0] = '0;

  for (genvar st = 0; st < CORDIC_STEPS; st++) begin : g_vec
    hvd_vec_cell #(
      .FRAC_BITS(FRAC_BITS),
      .IDX      (st)
    ) u_cell (
      .clk(clk),
      .x_i(vx[st]),
      .y_i(vy[st]),
      .z_i(vz[st]),
      .x_o(vx[st+1]),
      .y_o(vy[st+1]),
      .z_o(vz[st+1])
    );
  end

  logic signed [W-1:0]     ang_c;
  logic [R100W-1:0]        r100;
  logic signed [DW-1:0]    dist_p;

  always_comb begin
    ang_c = vz[CORDIC_STEPS][W-1] ? '0 : (vz[CORDIC_STEPS] <<< 1);
    r100  = R100W'(rad_r) * R100W'(100);
  end

  hvd_mul #(.AW(R100W), .BW(W), .OW(DW), .SHIFT(FRAC_BITS)) u_mul_dist (
    .clk(clk), .a_i($signed(r100)), .b_i(ang_c), .p_o(dist_p)
  );

  // saturate, blank same-unit pairs, compare with threshold
  logic [DistW-1:0] dsat, dist_nxt;
  logic [22:0]      thr100;
  logic             same_end;
  logic             inr_nxt;
  logic             out_valid_r, inr_r, same_out_r;
  logic [DistW-1:0] dist_r;

  always_comb begin
    same_end = same_r[LATENCY-2];
    thr100   = 23'(thr_r) * 23'd100;
    if (dist_p > DW'(34'sd2147483647)) dsat = {DistW{1'b1}};
    else dsat = dist_p[DistW-1:0];
    dist_nxt = same_end ? '0 : dsat;
    inr_nxt  = !same_end && (dist_nxt <= DistW'(thr100));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= vld_r[LATENCY-2];
  end

  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    inr_r      <= inr_nxt;
    same_out_r <= same_end;
  end

  assign out_valid       = out_valid_r;
  assign out_distance_cm = dist_r;
  assign out_in_range    = inr_r;
  assign out_same_unit   = same_out_r;

endmodule

>>> rtl/hvd_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_rot_cell
// One rotation-mode CORDIC iteration, registered; drives the angle toward zero.
// ----------------------------------------------------------------------------
module hvd_rot_cell #(
  parameter int FRAC_BITS = 30,
  parameter int IDX       = 0
) (
  input  logic                   clk,
  input  logic signed [FRAC_BITS+2:0] x_i,
  input  logic signed [FRAC_BITS+2:0] y_i,
  input  logic signed [FRAC_BITS+2:0] z_i,
  input  logic                   tag_i,
  output logic signed [FRAC_BITS+2:0] x_o,
  output logic signed [FRAC_BITS+2:0] y_o,
  output logic signed [FRAC_BITS+2:0] z_o,
  output logic                   tag_o
);
  import hvd_pkg::*;

  localparam int W = FRAC_BITS + 3;
  localparam logic [63:0] AtanFull = atan_qf(IDX, FRAC_BITS);
  localparam logic signed [W-1:0] Atan = AtanFull[W-1:0];

  logic signed [W-1:0] x_r, y_r, z_r;
  logic signed [W-1:0] x_nxt, y_nxt, z_nxt;
  logic                tag_r;

  always_comb begin
    if (z_i >= 0) begin
      x_nxt = x_i - (y_i >>> IDX);
      y_nxt = y_i + (x_i >>> IDX);
      z_nxt = z_i - Atan;
    end else begin
      x_nxt = x_i + (y_i >>> IDX);
      y_nxt = y_i - (x_i >>> IDX);
      z_nxt = z_i + Atan;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    tag_r <= tag_i;
  end

  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign tag_o = tag_r;

endmodule

>>> rtl/hvd_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_vec_cell
// One vectoring-mode CORDIC iteration, registered; accumulates the angle.
// ----------------------------------------------------------------------------
module hvd_vec_cell #(
  parameter int FRAC_BITS = 30,
  parameter int IDX       = 0
) (
  input  logic                   clk,
  input  logic signed [FRAC_BITS+2:0] x_i,
  input  logic signed [FRAC_BITS+2:0] y_i,
  input  logic signed [FRAC_BITS+2:0] z_i,
  output logic signed [FRAC_BITS+2:0] x_o,
  output logic signed [FRAC_BITS+2:0] y_o,
  output logic signed [FRAC_BITS+2:0] z_o
);
  import hvd_pkg::*;

  localparam int W = FRAC_BITS + 3;
  localparam logic [63:0] AtanFull = atan_qf(IDX, FRAC_BITS);
  localparam logic signed [W-1:0] Atan = AtanFull[W-1:0];

  logic signed [W-1:0] x_r, y_r, z_r;
  logic signed [W-1:0] x_nxt, y_nxt, z_nxt;

  // a zero y means the vector is on the axis: hold everything
  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> IDX);
      y_nxt = y_i - (x_i >>> IDX);
      z_nxt = z_i + Atan;
    end else if (y_i < 0) begin
      x_nxt = x_i - (y_i >>> IDX);
      y_nxt = y_i + (x_i >>> IDX);
      z_nxt = z_i - Atan;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

>>> rtl/hvd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_sqrt_cell
// One digit of a restoring square root of a * 2^FRAC_BITS, registered.
// ----------------------------------------------------------------------------
module hvd_sqrt_cell #(
  parameter int FRAC_BITS = 30,
  parameter int STEP      = 0
) (
  input  logic                 clk,
  input  logic [FRAC_BITS:0]   a_i,
  input  logic [FRAC_BITS+4:0] r_i,
  input  logic [FRAC_BITS+1:0] q_i,
  output logic [FRAC_BITS:0]   a_o,
  output logic [FRAC_BITS+4:0] r_o,
  output logic [FRAC_BITS+1:0] q_o
);
  import hvd_pkg::*;

  localparam int RW = FRAC_BITS + 5;
  localparam int QW = FRAC_BITS + 2;
  localparam int Hb = 2 * STEP + 1;
  localparam int Lb = 2 * STEP;

  logic [1:0]    pair;
  logic [RW-1:0] rem;
  logic [RW-1:0] trial;
  logic [RW-1:0] r_nxt;
  logic [QW-1:0] q_nxt;
  logic [FRAC_BITS:0] a_r;
  logic [RW-1:0] r_r;
  logic [QW-1:0] q_r;

  // bit pair of the scaled operand; bits below the fraction are zero
  if (Hb >= FRAC_BITS && Hb - FRAC_BITS <= FRAC_BITS) begin : g_hb
    assign pair[1] = a_i[Hb-FRAC_BITS];
  end else begin : g_hb0
    assign pair[1] = 1'b0;
  end
  if (Lb >= FRAC_BITS) begin : g_lb
    assign pair[0] = a_i[Lb-FRAC_BITS];
  end else begin : g_lb0
    assign pair[0] = 1'b0;
  end

  always_comb begin
    rem   = {r_i[RW-3:0], pair};
    trial = RW'({q_i, 2'b01});
    if (rem >= trial) begin
      r_nxt = rem - trial;
      q_nxt = {q_i[QW-2:0], 1'b1};
    end else begin
      r_nxt = rem;
      q_nxt = {q_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_i;
    r_r <= r_nxt;
    q_r <= q_nxt;
  end

  assign a_o = a_r;
  assign r_o = r_r;
  assign q_o = q_r;

endmodule

>>> rtl/hvd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_mul
// Signed fixed-point product (a * b) >> SHIFT truncated toward zero,
// three stages: magnitudes, half-width partial products, sum and sign.
// ----------------------------------------------------------------------------
module hvd_mul #(
  parameter int AW    = 33,
  parameter int BW    = 33,
  parameter int OW    = 33,
  parameter int SHIFT = 30
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [OW-1:0] p_o
);
  import hvd_pkg::*;

  localparam int LA = AW / 2;
  localparam int HA = AW - LA;
  localparam int LB = BW / 2;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW;

  logic [AW-1:0]    ma_r, ma_nxt;
  logic [BW-1:0]    mb_r, mb_nxt;
  logic             neg_r, neg2_r;
  logic [LA+LB-1:0] ll_r;
  logic [LA+HB-1:0] lh_r;
  logic [HA+LB-1:0] hl_r;
  logic [HA+HB-1:0] hh_r;
  logic [PW-1:0]    sum;
  logic [PW-1:0]    shifted;
  logic [OW-1:0]    trunc;
  logic [OW-1:0]    p_nxt;
  logic signed [OW-1:0] p_r;

  always_comb begin
    ma_nxt = a_i[AW-1] ? (~a_i + 1'b1) : a_i;
    mb_nxt = b_i[BW-1] ? (~b_i + 1'b1) : b_i;
  end

  always_comb begin
    sum = (PW'(hh_r) << (LA + LB)) + (PW'(hl_r) << LA) + (PW'(lh_r) << LB) + PW'(ll_r);
    shifted = sum >> SHIFT;
    trunc   = shifted[OW-1:0];
    p_nxt   = neg2_r ? (~trunc + 1'b1) : trunc;
  end

  always_ff @(posedge clk) begin
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    neg_r  <= a_i[AW-1] ^ b_i[BW-1];
    ll_r   <= ma_r[LA-1:0] * mb_r[LB-1:0];
    lh_r   <= ma_r[LA-1:0] * mb_r[BW-1:LB];
    hl_r   <= ma_r[AW-1:LA] * mb_r[LB-1:0];
    hh_r   <= ma_r[AW-1:LA] * mb_r[BW-1:LB];
    neg2_r <= neg_r;
    p_r    <= p_nxt;
  end

  assign p_o = p_r;

endmodule

>>> rtl/hvd_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_chk
// Port-level checks of the distance block: result timing and flag coherence.
// ----------------------------------------------------------------------------
module hvd_chk #(
  parameter int LATENCY = 96
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [hvd_pkg::DistW-1:0] out_distance_cm,
  input logic                      out_in_range,
  input logic                      out_same_unit
);
  import hvd_pkg::*;

  // every result comes from an item taken a fixed time earlier
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  a_same_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_same_unit) |-> (out_distance_cm == '0 && !out_in_range))
    else $error("same-unit result not blanked");

  a_range_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_range) |-> (out_distance_cm <= 31'd6553500))
    else $error("in range beyond any threshold");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind haversine_distance_proximity hvd_chk #(.LATENCY(LATENCY)) u_hvd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_distance_cm(out_distance_cm),
  .out_in_range   (out_in_range),
  .out_same_unit  (out_same_unit)
);
